// ===== rtl/idsp_pkg.sv =====
// Shared types and codes for the idle display power sequencer.
package idsp_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int TIMEOUT_W = 32;
   localparam int MASK_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_MASK = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_TIMEOUT = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_TIMEOUT = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP_TIMEOUT = 8'd3;

   localparam logic [MASK_W-1:0] ALLOW_MASK_RESET = 4'd15;
   localparam logic [TIMEOUT_W-1:0] DIM_TIMEOUT_RESET = 32'd30000;
   localparam logic [TIMEOUT_W-1:0] OFF_TIMEOUT_RESET = 32'd60000;
   localparam logic [TIMEOUT_W-1:0] SLEEP_TIMEOUT_RESET = 32'd120000;

   localparam int ALLOW_SAVE_BIT = 0;
   localparam int ALLOW_DIM_BIT = 1;
   localparam int ALLOW_OFF_BIT = 2;
   localparam int ALLOW_DEEP_BIT = 3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ACTIVITY = 1'b1;

   typedef enum logic [1:0] {
      MODE_ACTIVE = 2'd0,
      MODE_DIMMED = 2'd1,
      MODE_OFF    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      WAKE_NONE    = 2'd0,
      WAKE_RESTORE = 2'd1,
      WAKE_TURN_ON = 2'd2
   } wake_type;

   typedef enum logic [1:0] {
      SAVE_NONE = 2'd0,
      SAVE_DIM  = 2'd1,
      SAVE_OFF  = 2'd2
   } save_type;

   typedef struct packed {
      logic [MASK_W-1:0]    allow_mask;
      logic [TIMEOUT_W-1:0] dim_timeout;
      logic [TIMEOUT_W-1:0] off_timeout;
      logic [TIMEOUT_W-1:0] sleep_timeout;
   } cfg_type;

   typedef struct packed {
      wake_type wake_command;
      save_type save_command;
      logic     deep_sleep_request;
      mode_type display_mode;
      logic     on_usb;
   } result_type;

endpackage

// ===== rtl/idsp_csr.sv =====
// Configuration registers of the idle display power sequencer.
module idsp_csr
   import idsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIMEOUT_W-1:0]   csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ALLOW_MASK:    cfg_in.allow_mask = csr_data[MASK_W-1:0];
            CSR_DIM_TIMEOUT:   cfg_in.dim_timeout = csr_data;
            CSR_OFF_TIMEOUT:   cfg_in.off_timeout = csr_data;
            CSR_SLEEP_TIMEOUT: cfg_in.sleep_timeout = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.allow_mask <= ALLOW_MASK_RESET;
         cfg_ff.dim_timeout <= DIM_TIMEOUT_RESET;
         cfg_ff.off_timeout <= OFF_TIMEOUT_RESET;
         cfg_ff.sleep_timeout <= SLEEP_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/idsp_core.sv =====
// Idle counter, power source and display mode update for one request.
module idsp_core
   import idsp_pkg::*;
#(
   parameter int IDLE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       opcode,
   input  logic       usb_connected,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int CMP_W = (IDLE_WIDTH > TIMEOUT_W) ? IDLE_WIDTH : TIMEOUT_W;

   logic [IDLE_WIDTH-1:0] idle_ff;
   logic [IDLE_WIDTH-1:0] idle_in;
   logic                  usb_ff;
   logic                  usb_in;
   mode_type              mode_ff;
   mode_type              mode_in;

   logic [IDLE_WIDTH-1:0] idle_inc;
   logic [IDLE_WIDTH-1:0] idle_tick;
   logic [CMP_W-1:0]      idle_ext;
   logic                  dim_hit;
   logic                  off_hit;
   logic                  deep_hit;
   wake_type              wake;
   save_type              save;
   logic                  sleep_req;

   assign idle_inc = (&idle_ff) ? idle_ff : idle_ff + IDLE_WIDTH'(1);
   assign idle_tick = (usb_connected != usb_ff) ? '0 : idle_inc;
   assign idle_ext = CMP_W'(idle_tick);
   assign dim_hit = cfg.allow_mask[ALLOW_DIM_BIT] &&
                    (idle_ext >= CMP_W'(cfg.dim_timeout));
   assign off_hit = cfg.allow_mask[ALLOW_OFF_BIT] &&
                    (idle_ext >= CMP_W'(cfg.off_timeout));
   assign deep_hit = cfg.allow_mask[ALLOW_DEEP_BIT] &&
                     (idle_ext >= CMP_W'(cfg.sleep_timeout));

   always_comb begin
      idle_in = idle_ff;
      usb_in = usb_ff;
      mode_in = mode_ff;
      wake = WAKE_NONE;
      save = SAVE_NONE;
      sleep_req = 1'b0;
      if (opcode == OP_ACTIVITY) begin
         idle_in = '0;
         mode_in = MODE_ACTIVE;
         unique case (mode_ff)
            MODE_OFF:    wake = WAKE_TURN_ON;
            MODE_DIMMED: wake = WAKE_RESTORE;
            default:     wake = WAKE_NONE;
         endcase
      end else begin
         idle_in = idle_tick;
         if (usb_connected != usb_ff) begin
            usb_in = usb_connected;
            mode_in = MODE_ACTIVE;
            wake = (mode_ff == MODE_OFF) ? WAKE_TURN_ON : WAKE_RESTORE;
         end
         if (!usb_in && cfg.allow_mask[ALLOW_SAVE_BIT]) begin
            unique case (mode_in)
               MODE_ACTIVE: begin
                  if (dim_hit) begin
                     save = SAVE_DIM;
                     mode_in = MODE_DIMMED;
                  end else if (off_hit) begin
                     save = SAVE_OFF;
                     mode_in = MODE_OFF;
                  end
               end
               MODE_DIMMED: begin
                  if (off_hit) begin
                     save = SAVE_OFF;
                     mode_in = MODE_OFF;
                  end
               end
               default: sleep_req = deep_hit;
            endcase
         end
      end
   end

   always_comb begin
      result.wake_command = wake;
      result.save_command = save;
      result.deep_sleep_request = sleep_req;
      result.display_mode = mode_in;
      result.on_usb = usb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= '0;
         usb_ff <= 1'b0;
         mode_ff <= MODE_ACTIVE;
      end else if (step) begin
         idle_ff <= idle_in;
         usb_ff <= usb_in;
         mode_ff <= mode_in;
      end
   end

endmodule

// ===== rtl/idle_display_power_sequencer_top.sv =====
// Top level of the idle display power sequencer: request and response registers.
//
//   channel  direction  fields
//   req_     in         tuser: opcode; tdata: usb_connected (bit 0)
//   rsp_     out        tdata: wake, save, deep sleep, mode, on_usb
//   csr_     in         csr_index selects the register, csr_data the value
//
// One request per cycle while responses are taken; an accepted request passes
// through the request register, then the response register, to become valid.
// The state update happens as a request moves into the response register.
// Reset is synchronous and restores the register defaults and idle state.
// A stalled response holds; one more request waits in the request register.
module idle_display_power_sequencer_top
   import idsp_pkg::*;
#(
   parameter int IDLE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // [0] usb_connected, [7:1] zero
   input  logic                   req_tuser,  // [0] opcode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,  // [1:0] wake_command, [3:2] save_command,
                                              // [4] deep_sleep_request,
                                              // [6:5] display_mode, [7] on_usb
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIMEOUT_W-1:0]   csr_data
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       req_valid_ff;
   logic       req_opcode_ff;
   logic       req_usb_ff;
   logic       rsp_valid_ff;
   logic       rsp_open;
   logic       step;

   assign rsp_open = !rsp_valid_ff || rsp_tready;
   assign step = req_valid_ff && rsp_open;
   assign req_tready = !req_valid_ff || step;

   idsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   idsp_core #(
      .IDLE_WIDTH (IDLE_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .opcode        (req_opcode_ff),
      .usb_connected (req_usb_ff),
      .cfg           (cfg),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (rsp_open) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
      if (req_tready && req_tvalid) begin
         req_opcode_ff <= req_tuser;
         req_usb_ff <= req_tdata[0];
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_ff.on_usb, rsp_ff.display_mode, rsp_ff.deep_sleep_request,
                       rsp_ff.save_command, rsp_ff.wake_command};

`ifndef SYNTHESIS
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");
   a_save_on_battery: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.save_command != SAVE_NONE |-> !rsp_ff.on_usb)
      else $error("save command while on USB");
   a_sleep_only_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.deep_sleep_request |->
         rsp_ff.display_mode == MODE_OFF && rsp_ff.wake_command == WAKE_NONE &&
         rsp_ff.save_command == SAVE_NONE)
      else $error("deep sleep request outside display off");
   a_save_sets_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.save_command == SAVE_DIM |->
         rsp_ff.display_mode == MODE_DIMMED)
      else $error("dim command without dimmed mode");
`endif

endmodule
